// ----- rtl/rior_pkg.sv -----
// Shared types and constants for the reliable in-order receiver.
// No dependencies; used by rior_store and reliable_in_order_receiver.
package rior_pkg;

  // Default sizes
  localparam int WINDOW_DEF   = 16;
  localparam int ID_BITS_DEF  = 16;
  localparam int TAG_BITS_DEF = 8;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DELIVERED  = 3'd0,
    ST_UNRELIABLE = 3'd1,
    ST_LATE_DUP   = 3'd2,
    ST_PARKED     = 3'd3,
    ST_ALREADY    = 3'd4,
    ST_BEYOND     = 3'd5
  } status_t;

  // Update requests from the sequencer to the parked-packet store
  typedef struct packed {
    logic park;   // write tag and set valid at the park slot
    logic clear;  // drop valid at the drain slot
  } store_ctl_t;

endpackage

// ----- rtl/rior_store.sv -----
// Parked-packet store: per-slot valid flags and a tag memory with a registered read.
// Depends on rior_pkg (store_ctl_t).
module rior_store #(
  parameter int WINDOW    = rior_pkg::WINDOW_DEF,
  parameter int TAG_BITS  = rior_pkg::TAG_BITS_DEF,
  parameter int SLOT_BITS = $clog2(WINDOW)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rior_pkg::store_ctl_t   ctl,
  input  logic [SLOT_BITS-1:0]   wr_addr,
  input  logic [TAG_BITS-1:0]    wr_tag,
  input  logic [SLOT_BITS-1:0]   clr_addr,
  input  logic [SLOT_BITS-1:0]   q_addr,
  output logic                   q_valid,
  output logic [TAG_BITS-1:0]    rd_tag
);

  logic [WINDOW-1:0]   valid;
  logic [TAG_BITS-1:0] mem [WINDOW];

  // Valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.park) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.clear) begin
        valid[clr_addr] <= 1'b0;
      end
    end
  end

  assign q_valid = valid[q_addr];

  // Tag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.park) begin
      mem[wr_addr] <= wr_tag;
    end
    rd_tag <= mem[q_addr];
  end

endmodule

// ----- rtl/reliable_in_order_receiver.sv -----
// Top level of the reliable in-order receiver: packet classification and drain sequencer.
// Depends on rior_pkg and rior_store.

// A packet request is taken when start is high and busy is low; its first result
// shows on the result ports, marked by strobe, in the following cycle and is held
// for that one cycle only, since the receiver cannot stall. Unreliable, late,
// beyond-window and parked packets give one result and leave busy low, so a new
// packet may follow every cycle. The next expected packet gives its own result and
// then one result per cycle for each consecutive parked packet (up to WINDOW results
// in all); busy stays high while the chain drains, paced by the single read port of
// the tag memory. last marks the final result of each packet.
module reliable_in_order_receiver #(
  parameter int WINDOW   = rior_pkg::WINDOW_DEF,
  parameter int ID_BITS  = rior_pkg::ID_BITS_DEF,
  parameter int TAG_BITS = rior_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                reliable,
  input  logic [ID_BITS-1:0]  packet_id,
  input  logic [TAG_BITS-1:0] buffer_tag,
  output logic                strobe,
  output logic                deliver_valid,
  output logic [TAG_BITS-1:0] deliver_tag,
  output logic                ack_valid,
  output logic [ID_BITS-1:0]  ack_id,
  output logic [2:0]          status,
  output logic                last
);

  localparam int SLOT_BITS = $clog2(WINDOW);
  localparam int CNT_BITS  = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t                state;
  logic [ID_BITS-1:0]    last_id;
  logic [SLOT_BITS-1:0]  last_slot;
  logic [SLOT_BITS-1:0]  drain_slot;
  logic [CNT_BITS-1:0]   count;

  logic                  accept;
  logic [ID_BITS:0]      id_ext;
  logic [ID_BITS:0]      last_ext;
  logic [ID_BITS:0]      diff;
  logic                  is_late;
  logic                  is_next;
  logic                  is_beyond;
  logic [SLOT_BITS:0]    park_sum;
  logic [SLOT_BITS-1:0]  park_slot;
  logic [SLOT_BITS-1:0]  next_slot;
  logic [SLOT_BITS-1:0]  after_slot;
  logic [SLOT_BITS-1:0]  q_addr;
  logic                  q_valid;
  logic [TAG_BITS-1:0]   rd_tag;
  logic [ID_BITS-1:0]    drain_id;
  logic                  first_cont;
  logic                  drain_cont;
  rior_pkg::store_ctl_t  ctl;

  function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
    if (s == SLOT_BITS'(WINDOW - 1)) begin
      slot_inc = '0;
    end else begin
      slot_inc = s + 1'b1;
    end
  endfunction

  assign busy   = (state == S_DRAIN);
  assign accept = start && !busy;

  // Classify the incoming id against the last delivered one
  always_comb begin
    id_ext    = {1'b0, packet_id};
    last_ext  = {1'b0, last_id};
    diff      = id_ext - last_ext;
    is_late   = (id_ext <= last_ext);
    is_next   = (id_ext == last_ext + 1'b1);
    is_beyond = (diff > (ID_BITS + 1)'(WINDOW));
    // Slot of a parked id: last slot plus distance, folded once
    park_sum  = {1'b0, last_slot} + diff[SLOT_BITS:0];
    if (park_sum >= (SLOT_BITS + 1)'(WINDOW)) begin
      park_slot = SLOT_BITS'(park_sum - (SLOT_BITS + 1)'(WINDOW));
    end else begin
      park_slot = park_sum[SLOT_BITS-1:0];
    end
    next_slot  = slot_inc(last_slot);
    after_slot = slot_inc(next_slot);
  end

  // Store query: next drain slot while draining, else park or chain slot
  always_comb begin
    if (state == S_DRAIN) begin
      q_addr = slot_inc(drain_slot);
    end else if (is_next) begin
      q_addr = after_slot;
    end else begin
      q_addr = park_slot;
    end
    drain_id   = last_id + 1'b1;
    first_cont = (packet_id != '1) && q_valid;
    drain_cont = (drain_id != '1) && q_valid && (count < CNT_BITS'(WINDOW - 1));
    ctl.park   = accept && reliable && !is_late && !is_next && !is_beyond && !q_valid;
    ctl.clear  = (state == S_DRAIN);
  end

  rior_store #(
    .WINDOW    (WINDOW),
    .TAG_BITS  (TAG_BITS),
    .SLOT_BITS (SLOT_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .wr_addr  (park_slot),
    .wr_tag   (buffer_tag),
    .clr_addr (drain_slot),
    .q_addr   (q_addr),
    .q_valid  (q_valid),
    .rd_tag   (rd_tag)
  );

  // Control: sequencer state, delivery point and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      last_id   <= '0;
      last_slot <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            strobe <= 1'b1;
            if (reliable && is_next) begin
              last_id   <= packet_id;
              last_slot <= next_slot;
              if (first_cont) begin
                state <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          strobe    <= 1'b1;
          last_id   <= drain_id;
          last_slot <= drain_slot;
          if (!drain_cont) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload and drain bookkeeping
  always_ff @(posedge clk) begin
    if (state == S_DRAIN) begin
      deliver_valid <= 1'b1;
      deliver_tag   <= rd_tag;
      ack_valid     <= 1'b1;
      ack_id        <= drain_id;
      status        <= rior_pkg::ST_DELIVERED;
      last          <= !drain_cont;
      drain_slot    <= slot_inc(drain_slot);
      count         <= count + 1'b1;
    end else if (accept) begin
      deliver_valid <= 1'b0;
      deliver_tag   <= '0;
      ack_valid     <= 1'b0;
      ack_id        <= '0;
      last          <= 1'b1;
      drain_slot    <= after_slot;
      count         <= CNT_BITS'(1);
      if (!reliable) begin
        deliver_valid <= 1'b1;
        deliver_tag   <= buffer_tag;
        status        <= rior_pkg::ST_UNRELIABLE;
      end else if (is_late) begin
        status <= rior_pkg::ST_LATE_DUP;
      end else if (is_next) begin
        deliver_valid <= 1'b1;
        deliver_tag   <= buffer_tag;
        ack_valid     <= 1'b1;
        ack_id        <= packet_id;
        status        <= rior_pkg::ST_DELIVERED;
        last          <= !first_cont;
      end else if (is_beyond) begin
        status <= rior_pkg::ST_BEYOND;
      end else if (q_valid) begin
        status <= rior_pkg::ST_ALREADY;
      end else begin
        status <= rior_pkg::ST_PARKED;
      end
    end
  end

`ifndef SYNTHESIS
  // Every drain step produces a delivered result in the next cycle
  a_drain_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (strobe && deliver_valid && ack_valid &&
                            status == rior_pkg::ST_DELIVERED))
    else $error("drain step without delivered result");

  // A non-final result is only ever followed by more draining
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (state == S_DRAIN))
    else $error("non-final result while sequencer idle");

  // Draining never runs past the highest id
  a_drain_id_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (last_id != '1))
    else $error("drain beyond highest id");

  // One packet never yields more than WINDOW results
  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (count < CNT_BITS'(WINDOW)))
    else $error("drain count overrun");
`endif

endmodule

// ----- test/rior_checker.sv -----
// Checker for the reliable in-order receiver: keeps its own copy of the window store,
// works out every result of each accepted packet request and compares strobed results.
// Depends on rior_pkg; instantiated by reliable_in_order_receiver_tb.
module rior_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              reliable,
  input  logic [rior_pkg::ID_BITS_DEF-1:0]  packet_id,
  input  logic [rior_pkg::TAG_BITS_DEF-1:0] buffer_tag,
  input  logic                              strobe,
  input  logic                              deliver_valid,
  input  logic [rior_pkg::TAG_BITS_DEF-1:0] deliver_tag,
  input  logic                              ack_valid,
  input  logic [rior_pkg::ID_BITS_DEF-1:0]  ack_id,
  input  logic [2:0]                        status,
  input  logic                              last,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN   = rior_pkg::WINDOW_DEF;
  localparam int ID_W  = rior_pkg::ID_BITS_DEF;
  localparam int TAG_W = rior_pkg::TAG_BITS_DEF;

  // One result as it should appear on the result ports
  typedef struct packed {
    logic              dv;
    logic [TAG_W-1:0]  tag;
    logic              av;
    logic [ID_W-1:0]   aid;
    rior_pkg::status_t st;
    logic              fin;
  } outcome_t;

  outcome_t         outcome_q[$];
  logic [ID_W-1:0]  delivered_id;
  logic             slot_full [WIN];
  logic [TAG_W-1:0] slot_tag [WIN];
  int               results_seen;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] result %0d: %s", $time, results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [ID_W-1:0] got,
                             input logic [ID_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Append one expected result at the tail of the queue
  task automatic enqueue_result(input outcome_t r);
    outcome_q.insert(outcome_q.size(), r);
  endtask

  // Classify one packet request, update the window copy, queue its results
  task automatic classify_packet(input logic rel, input logic [ID_W-1:0] id,
                                 input logic [TAG_W-1:0] tag);
    int              slot;
    int              k;
    int              j;
    logic [ID_W-1:0] run_end;
    logic [ID_W-1:0] nid;
    slot = int'(id % WIN);
    if (!rel) begin
      enqueue_result('{1'b1, tag, 1'b0, '0, rior_pkg::ST_UNRELIABLE, 1'b1});
    end else if (id <= delivered_id) begin
      enqueue_result('{1'b0, '0, 1'b0, '0, rior_pkg::ST_LATE_DUP, 1'b1});
    end else if (id - delivered_id > WIN) begin
      enqueue_result('{1'b0, '0, 1'b0, '0, rior_pkg::ST_BEYOND, 1'b1});
    end else if (id != delivered_id + 1'b1) begin
      // ahead but inside the window: park unless the slot is taken
      if (slot_full[slot]) begin
        enqueue_result('{1'b0, '0, 1'b0, '0, rior_pkg::ST_ALREADY, 1'b1});
      end else begin
        slot_full[slot] = 1'b1;
        slot_tag[slot]  = tag;
        enqueue_result('{1'b0, '0, 1'b0, '0, rior_pkg::ST_PARKED, 1'b1});
      end
    end else begin
      // next expected: find how far the parked chain runs, capped by the window
      k       = 0;
      run_end = id;
      while (run_end != {ID_W{1'b1}} && k + 1 < WIN &&
             slot_full[int'((run_end + 1'b1) % WIN)]) begin
        k++;
        run_end++;
      end
      enqueue_result('{1'b1, tag, 1'b1, id, rior_pkg::ST_DELIVERED, k == 0});
      for (j = 1; j <= k; j++) begin
        nid  = id + ID_W'(j);
        slot = int'(nid % WIN);
        enqueue_result('{1'b1, slot_tag[slot], 1'b1, nid, rior_pkg::ST_DELIVERED, j == k});
        slot_full[slot] = 1'b0;
      end
      delivered_id = run_end;
    end
  endtask

  // Results are checked before the request of the same edge is classified:
  // a result never belongs to a request taken at that very edge.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      delivered_id = '0;
      for (int s = 0; s < WIN; s++) slot_full[s] = 1'b0;
      outcome_q.delete();
    end else begin
      if ($isunknown(strobe)) begin
        report_mismatch("strobe is unknown");
      end else if (strobe) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no packet request waiting");
        end else begin
          want = outcome_q.pop_front();
          check_field("deliver_valid", ID_W'(deliver_valid), ID_W'(want.dv));
          check_field("deliver_tag", ID_W'(deliver_tag), ID_W'(want.tag));
          check_field("ack_valid", ID_W'(ack_valid), ID_W'(want.av));
          check_field("ack_id", ack_id, want.aid);
          check_field("status", ID_W'(status), ID_W'(want.st));
          check_field("last", ID_W'(last), ID_W'(want.fin));
        end
        results_seen++;
      end
      if (start && busy === 1'b0)
        classify_packet(reliable, packet_id, buffer_tag);
    end
    pending <= outcome_q.size();
  end

endmodule

// ----- test/reliable_in_order_receiver_tb.sv -----
// Testbench top for the reliable in-order receiver: drives packet requests and gives
// the verdict. Depends on rior_pkg, reliable_in_order_receiver and rior_checker.
module reliable_in_order_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;

  typedef enum {NZ_UNRELIABLE, NZ_LATE, NZ_BEYOND, NZ_REPEAT} noise_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic        reliable   = 1'b0;
  logic [15:0] packet_id  = '0;
  logic [7:0]  buffer_tag = '0;
  logic        busy;
  logic        strobe;
  logic        deliver_valid;
  logic [7:0]  deliver_tag;
  logic        ack_valid;
  logic [15:0] ack_id;
  logic [2:0]  status;
  logic        last;

  int mismatches;
  int in_flight;
  int gap_pct        = 0;
  int delivered_upto = 0;  // highest id known delivered once the stream settles
  int cycle_count    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  reliable_in_order_receiver dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .reliable(reliable),
    .packet_id(packet_id), .buffer_tag(buffer_tag), .strobe(strobe),
    .deliver_valid(deliver_valid), .deliver_tag(deliver_tag), .ack_valid(ack_valid),
    .ack_id(ack_id), .status(status), .last(last)
  );

  rior_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .reliable(reliable),
    .packet_id(packet_id), .buffer_tag(buffer_tag), .strobe(strobe),
    .deliver_valid(deliver_valid), .deliver_tag(deliver_tag), .ack_valid(ack_valid),
    .ack_id(ack_id), .status(status), .last(last),
    .fail_count(mismatches), .pending(in_flight)
  );

  // Hold one packet request until taken, then maybe idle for a while
  task automatic send_packet(input logic rel, input logic [15:0] id, input logic [7:0] tag);
    start      <= 1'b1;
    reliable   <= rel;
    packet_id  <= id;
    buffer_tag <= tag;
    do @(posedge clk); while (busy !== 1'b0);
    if ($urandom_range(99) < gap_pct) begin
      // idle cycles carry junk on the fields
      start      <= 1'b0;
      reliable   <= 1'($urandom);
      packet_id  <= 16'($urandom);
      buffer_tag <= 8'($urandom);
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  // Runs of consecutive ids sent out of order, mixed with late, beyond-window,
  // repeated and unreliable packets
  task automatic run_bursts(input int n_items);
    logic [15:0] ids [16];
    logic [15:0] tmp;
    int          len;
    int          i;
    int          j;
    int          done;
    noise_t      kind;
    done = 0;
    while (done < n_items) begin
      len = $urandom_range(16, 1);
      for (i = 0; i < len; i++) ids[i] = 16'(delivered_upto + 1 + i);
      for (i = len - 1; i > 0; i--) begin
        j      = $urandom_range(i, 0);
        tmp    = ids[i];
        ids[i] = ids[j];
        ids[j] = tmp;
      end
      for (i = 0; i < len; i++) begin
        while ($urandom_range(99) < 25) begin
          kind = noise_t'($urandom_range(3, 0));
          case (kind)
            NZ_LATE:
              send_packet(1'b1, 16'($urandom_range(delivered_upto, 0)), 8'($urandom));
            NZ_BEYOND:
              send_packet(1'b1, 16'($urandom_range(65535, delivered_upto + len + 17)),
                          8'($urandom));
            NZ_REPEAT:
              if (i > 0) send_packet(1'b1, ids[$urandom_range(i - 1, 0)], 8'($urandom));
              else send_packet(1'b0, 16'($urandom), 8'($urandom));
            default:
              send_packet(1'b0, 16'($urandom), 8'($urandom));
          endcase
          done++;
        end
        send_packet(1'b1, ids[i], 8'($urandom));
        done++;
      end
      delivered_upto += len;
    end
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst     <= 1'b0;
    gap_pct = 26;

    // directed: field extremes, every status, a full-length drain
    send_packet(1'b0, 16'hFFFF, 8'hFF);
    send_packet(1'b0, 16'h0000, 8'h00);
    send_packet(1'b1, 16'd0, 8'h5A);    // late duplicate of the reset id
    send_packet(1'b1, 16'd3, 8'h33);    // parked
    send_packet(1'b1, 16'd3, 8'hC3);    // already parked
    send_packet(1'b1, 16'd2, 8'h22);    // parked
    send_packet(1'b1, 16'd17, 8'h71);   // just beyond the window
    send_packet(1'b1, 16'd16, 8'hA5);   // last id inside the window
    send_packet(1'b1, 16'd1, 8'h11);    // delivers 1, drains 2 and 3
    send_packet(1'b1, 16'd3, 8'h3C);    // late duplicate
    for (i = 5; i <= 19; i++)
      if (i != 16) send_packet(1'b1, 16'(i), 8'($urandom));
    send_packet(1'b1, 16'd4, 8'h44);    // drain capped at a full window of results
    delivered_upto = 19;
    hold_until_drained();

    // random phases with different sender idling
    run_bursts(90);
    hold_until_drained();
    gap_pct = 69;
    run_bursts(90);
    hold_until_drained();
    gap_pct = 0;
    run_bursts(90);
    hold_until_drained();

    // far ids, the reset id and a random tail
    send_packet(1'b1, 16'hFFFF, 8'h0F);
    send_packet(1'b1, 16'h0000, 8'hF0);
    send_packet(1'b0, 16'hABCD, 8'h96);
    repeat (20) send_packet(1'($urandom), 16'($urandom), 8'($urandom));
    hold_until_drained();
    repeat (40) @(posedge clk);

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
